FILE: design/mqts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the message queue with target search.
// No dependencies; every other file of the block uses this package.
package mqts_pkg;

  localparam int IDX_W = 8;
  localparam int CNT_W_MAX = 9;
  localparam int SCAN_W = 8;

  localparam logic [1:0] ACT_ENQ = 2'd0;
  localparam logic [1:0] ACT_DEQ = 2'd1;
  localparam logic [1:0] ACT_FIND = 2'd2;
  localparam logic [1:0] ACT_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_LOAD = 2'd1;
  localparam logic [1:0] CELL_SHIFT = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] target_pid;
    logic [31:0] message_handle;
    logic [3:0]  position;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [31:0] out_pid;
    logic [3:0]  found_position;
    logic [4:0]  entry_count;
    logic        is_empty;
  } rsp_word_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] sel;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: design/mqts_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels for request and response words of the queue.
// Depends on mqts_pkg for the word types.
interface mqts_req_if;
  logic valid;
  logic ready;
  mqts_pkg::req_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface mqts_rsp_if;
  logic valid;
  logic ready;
  mqts_pkg::rsp_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

FILE: design/message_queue_with_target_search_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Enqueue, dequeue and remove give their response word in the cycle after acceptance,
// and a new request is taken every cycle while no find is scanning and the response
// register drains. Find compares the cell row in the accept cycle, then the match
// vector is scanned eight cells per cycle until the first match or the last group.
// Reset clears the entry count and the handshake state; entry storage is not reset.
module message_queue_with_target_search_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  mqts_req_if.sink  req,
  mqts_rsp_if.source rsp
);
  import mqts_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int NCHUNK = (DEPTH + SCAN_W - 1) / SCAN_W;
  localparam int PAD_W = NCHUNK * SCAN_W;
  localparam int CHW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic            state;
  logic            state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            out_valid;
  rsp_word_t       out_word;
  rsp_word_t       out_word_next;
  logic            out_load;
  logic [PAD_W-1:0] match_q;
  logic [PAD_W-1:0] match_next;
  logic [CHW-1:0]  chunk_cnt;
  logic [CHW-1:0]  chunk_cnt_next;

  cell_cmd_t       cmd;
  logic [31:0]     cell_pid [DEPTH];
  logic [31:0]     cell_handle [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [PAD_W-1:0] live_match;

  logic            out_free;
  logic            accept;
  logic [IDX_W-1:0] pos_ext;
  logic [IW-1:0]   pos_idx;
  logic [CNT_W_MAX-1:0] count_wide;
  logic [CNT_W_MAX-1:0] count_next_wide;
  logic            full;
  logic            pos_ok;
  logic            hit;
  logic [2:0]      hit_idx;
  logic [CHW+2:0]  found_full;

  assign out_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.word = out_word;

  assign pos_ext = IDX_W'(req.word.position);
  assign pos_idx = pos_ext[IW-1:0];
  assign count_wide = CNT_W_MAX'(count);
  assign count_next_wide = CNT_W_MAX'(count_next);
  assign full = (count == CW'(DEPTH));
  assign pos_ok = (CNT_W_MAX'(req.word.position) < count_wide);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_last
        mqts_cell #(.INDEX(g)) u_cell (
          .clk(clk), .cmd(cmd),
          .in_pid(req.word.target_pid), .in_handle(req.word.message_handle),
          .nxt_pid(cell_pid[g]), .nxt_handle(cell_handle[g]),
          .key(req.word.target_pid),
          .pid(cell_pid[g]), .handle(cell_handle[g]), .match(cell_match[g])
        );
      end else begin : g_mid
        mqts_cell #(.INDEX(g)) u_cell (
          .clk(clk), .cmd(cmd),
          .in_pid(req.word.target_pid), .in_handle(req.word.message_handle),
          .nxt_pid(cell_pid[g+1]), .nxt_handle(cell_handle[g+1]),
          .key(req.word.target_pid),
          .pid(cell_pid[g]), .handle(cell_handle[g]), .match(cell_match[g])
        );
      end
      assign live_match[g] = cell_match[g] && (CW'(g) < count);
    end
    for (g = DEPTH; g < PAD_W; g++) begin : g_pad
      assign live_match[g] = 1'b0;
    end
  endgenerate

  always_comb begin
    hit = 1'b0;
    hit_idx = 3'd0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  assign found_full = {chunk_cnt, hit_idx};

  always_comb begin
    state_next = state;
    count_next = count;
    out_load = 1'b0;
    match_next = match_q;
    chunk_cnt_next = chunk_cnt;
    cmd.op = CELL_HOLD;
    cmd.sel = '0;
    out_word_next = out_word;
    out_word_next.status = ST_OK;
    out_word_next.out_handle = '0;
    out_word_next.out_pid = '0;
    out_word_next.found_position = '0;

    if (state == S_IDLE) begin
      if (accept) begin
        case (req.word.action)
          ACT_ENQ: begin
            out_load = 1'b1;
            if (full) begin
              out_word_next.status = ST_FULL;
            end else begin
              cmd.op = CELL_LOAD;
              cmd.sel = count_wide[IDX_W-1:0];
              count_next = count + CW'(1);
            end
          end
          ACT_DEQ: begin
            out_load = 1'b1;
            if (count == '0) begin
              out_word_next.status = ST_MISS;
            end else begin
              cmd.op = CELL_SHIFT;
              cmd.sel = '0;
              out_word_next.out_handle = cell_handle[0];
              out_word_next.out_pid = cell_pid[0];
              count_next = count - CW'(1);
            end
          end
          ACT_FIND: begin
            match_next = live_match;
            chunk_cnt_next = '0;
            state_next = S_SCAN;
          end
          ACT_REMOVE: begin
            out_load = 1'b1;
            if (!pos_ok) begin
              out_word_next.status = ST_MISS;
            end else begin
              cmd.op = CELL_SHIFT;
              cmd.sel = pos_ext;
              out_word_next.out_handle = cell_handle[pos_idx];
              out_word_next.out_pid = cell_pid[pos_idx];
              count_next = count - CW'(1);
            end
          end
          default: begin
            out_load = 1'b0;
          end
        endcase
      end
    end else begin
      if (hit || chunk_cnt == CHW'(NCHUNK - 1)) begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = S_IDLE;
          if (hit) begin
            out_word_next.found_position = found_full[3:0];
          end else begin
            out_word_next.status = ST_MISS;
          end
        end
      end else begin
        match_next = match_q >> SCAN_W;
        chunk_cnt_next = chunk_cnt + CHW'(1);
      end
    end

    out_word_next.entry_count = count_next_wide[4:0];
    out_word_next.is_empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    match_q <= match_next;
    chunk_cnt <= chunk_cnt_next;
    if (out_load) begin
      out_word <= out_word_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/mqts_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One queue slot: holds a target id and a message handle, loads a new entry
// or takes its neighbor's entry when the row closes a gap. Uses mqts_pkg.
module mqts_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                 clk,
  input  wire mqts_pkg::cell_cmd_t  cmd,
  input  wire logic [31:0]          in_pid,
  input  wire logic [31:0]          in_handle,
  input  wire logic [31:0]          nxt_pid,
  input  wire logic [31:0]          nxt_handle,
  input  wire logic [31:0]          key,
  output logic [31:0]               pid,
  output logic [31:0]               handle,
  output logic                      match
);
  import mqts_pkg::*;

  logic at_sel;
  logic above_sel;

  assign at_sel = (cmd.sel == IDX_W'(INDEX));
  assign above_sel = (IDX_W'(INDEX) >= cmd.sel);
  assign match = (pid == key);

  always_ff @(posedge clk) begin
    if (cmd.op == CELL_LOAD && at_sel) begin
      pid <= in_pid;
      handle <= in_handle;
    end else if (cmd.op == CELL_SHIFT && above_sel) begin
      pid <= nxt_pid;
      handle <= nxt_handle;
    end
  end

endmodule
`default_nettype wire

FILE: design/mqts_check.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the message queue, attached to the top level by bind.
// Depends on mqts_pkg for status codes.
module mqts_check #(
  parameter int DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] out_handle,
  input wire logic [31:0] out_pid,
  input wire logic [3:0]  found_position,
  input wire logic [4:0]  entry_count,
  input wire logic        is_empty
);
  import mqts_pkg::*;

  localparam int CNT_LIMIT = (DEPTH > 31) ? 31 : DEPTH;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_handle)
      && $stable(out_pid) && $stable(found_position) && $stable(entry_count))
    else $error("response word changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == 5'd0)) || (DEPTH > 31))
    else $error("empty flag disagrees with entry count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == 5'(DEPTH) && !is_empty)
    else $error("full status without a full queue");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> out_handle == 32'd0 && out_pid == 32'd0
      && found_position == 4'd0)
    else $error("failed action reports entry data");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && DEPTH <= 31 |-> entry_count <= 5'(CNT_LIMIT) && status != 2'd3)
    else $error("entry count beyond depth or unknown status");

endmodule

bind message_queue_with_target_search_unit mqts_check #(.DEPTH(DEPTH)) u_mqts_check (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .status(rsp.word.status),
  .out_handle(rsp.word.out_handle),
  .out_pid(rsp.word.out_pid),
  .found_position(rsp.word.found_position),
  .entry_count(rsp.word.entry_count),
  .is_empty(rsp.word.is_empty)
);
`default_nettype wire

FILE: verif/mqts_response_checker.sv
`timescale 1ns / 1ps
// Response checker for the message queue: watches both channels, keeps its own copy
// of the entry rows, and compares every response word with the predicted one.
// Depends on mqts_pkg for the word types and the action and status codes.
module mqts_response_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  mqts_pkg::req_word_t  req_word,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  mqts_pkg::rsp_word_t  rsp_word,
  output int                   fail_count,
  output int                   words_due
);
  import mqts_pkg::*;

  localparam int QDEPTH = 16;

  logic [31:0] pid_row [QDEPTH];
  logic [31:0] handle_row [QDEPTH];
  int fill;
  rsp_word_t due_words [$];
  rsp_word_t want;

  initial begin
    fail_count = 0;
    words_due = 0;
    fill = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, exp_val);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch(what, got, exp_val);
    end
  endtask

  function automatic logic [63:0] pull_entry(input int at);
    logic [63:0] taken;
    int i;
    taken = {handle_row[at], pid_row[at]};
    for (i = at; i + 1 < fill; i++) begin
      pid_row[i] = pid_row[i + 1];
      handle_row[i] = handle_row[i + 1];
    end
    fill--;
    return taken;
  endfunction

  function automatic rsp_word_t apply_action(input req_word_t w);
    rsp_word_t r;
    int i;
    int hit;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_ENQ: begin
        if (fill >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          pid_row[fill] = w.target_pid;
          handle_row[fill] = w.message_handle;
          fill++;
        end
      end
      ACT_DEQ: begin
        if (fill == 0) begin
          r.status = ST_MISS;
        end else begin
          {r.out_handle, r.out_pid} = pull_entry(0);
        end
      end
      ACT_FIND: begin
        hit = -1;
        for (i = 0; i < fill; i++) begin
          if (hit < 0 && pid_row[i] == w.target_pid) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.found_position = hit[3:0];
        end
      end
      default: begin
        if (int'(w.position) >= fill) begin
          r.status = ST_MISS;
        end else begin
          {r.out_handle, r.out_pid} = pull_entry(int'(w.position));
        end
      end
    endcase
    r.entry_count = fill[4:0];
    r.is_empty = (fill == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      due_words.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_words.size() == 0) begin
          report_mismatch("unexpected response word", rsp_word.out_handle, 32'h0);
        end else begin
          want = due_words.pop_front();
          check_field("status", 32'(rsp_word.status), 32'(want.status));
          check_field("out_handle", rsp_word.out_handle, want.out_handle);
          check_field("out_pid", rsp_word.out_pid, want.out_pid);
          check_field("found_position", 32'(rsp_word.found_position),
                      32'(want.found_position));
          check_field("entry_count", 32'(rsp_word.entry_count), 32'(want.entry_count));
          check_field("is_empty", 32'(rsp_word.is_empty), 32'(want.is_empty));
        end
      end
      if (req_valid && req_ready) begin
        due_words.push_back(apply_action(req_word));
      end
    end
    words_due <= due_words.size();
  end

endmodule

FILE: verif/message_queue_with_target_search_unit_test.sv
`timescale 1ns / 1ps
// Top of the message queue testbench: clock, reset, request stimulus and response
// back-pressure. Depends on mqts_pkg, the channel interfaces, the block and the checker.
module message_queue_with_target_search_unit_test;
  import mqts_pkg::*;

  logic clk;
  logic rst;
  int fail_count;
  int words_due;
  bit send_steady;
  bit recv_steady;
  int recv_hold_cycles;
  logic [31:0] pid_pool [8];

  mqts_req_if req_ch ();
  mqts_rsp_if rsp_ch ();

  message_queue_with_target_search_unit #(.DEPTH(16)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  mqts_response_checker checker_inst (
    .clk(clk),
    .rst(rst),
    .req_valid(req_ch.valid),
    .req_ready(req_ch.ready),
    .req_word(req_ch.word),
    .rsp_valid(rsp_ch.valid),
    .rsp_ready(rsp_ch.ready),
    .rsp_word(rsp_ch.word),
    .fail_count(fail_count),
    .words_due(words_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic req_word_t word_of(input logic [1:0] act, input logic [31:0] pid,
                                        input logic [31:0] handle, input logic [3:0] pos);
    req_word_t w;
    w.action = act;
    w.target_pid = pid;
    w.message_handle = handle;
    w.position = pos;
    return w;
  endfunction

  function automatic req_word_t random_word(input bit filling);
    int pick;
    logic [1:0] act;
    logic [31:0] pid;
    pick = $urandom_range(0, 99);
    if (filling) begin
      act = (pick < 55) ? ACT_ENQ : (pick < 70) ? ACT_DEQ : (pick < 85) ? ACT_FIND : ACT_REMOVE;
    end else begin
      act = (pick < 20) ? ACT_ENQ : (pick < 50) ? ACT_DEQ : (pick < 70) ? ACT_FIND : ACT_REMOVE;
    end
    pid = ($urandom_range(0, 3) == 0) ? $urandom : pid_pool[$urandom_range(0, 7)];
    return word_of(act, pid, $urandom, 4'($urandom_range(0, 15)));
  endfunction

  task automatic send(input req_word_t w);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.word <= w;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain_all;
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    recv_hold_cycles = 0;
    recv_steady = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (recv_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (recv_hold_cycles) @(posedge clk);
        recv_hold_cycles = 0;
      end else begin
        stall = recv_steady ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  initial begin
    int i;
    int phase;
    req_ch.valid <= 1'b0;
    req_ch.word <= '0;
    send_steady = 1'b0;
    rst <= 1'b1;
    pid_pool[0] = 32'h0000_0000;
    pid_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < 8; i++) begin
      pid_pool[i] = $urandom;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(word_of(ACT_ENQ, 32'h0000_0000, 32'h0000_0000, 4'd0));
    send(word_of(ACT_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15));
    send(word_of(ACT_FIND, 32'hFFFF_FFFF, 32'h0, 4'd0));
    send(word_of(ACT_FIND, 32'h0000_0000, 32'h0, 4'd0));
    send(word_of(ACT_FIND, 32'h5A5A_5A5A, 32'h0, 4'd0));
    send(word_of(ACT_REMOVE, 32'h0, 32'h0, 4'd1));
    send(word_of(ACT_REMOVE, 32'h0, 32'h0, 4'd1));
    send(word_of(ACT_REMOVE, 32'h0, 32'h0, 4'd0));
    send(word_of(ACT_DEQ, 32'h0, 32'h0, 4'd0));
    send(word_of(ACT_REMOVE, 32'h0, 32'h0, 4'd15));
    for (i = 0; i < 16; i++) begin
      send(word_of(ACT_ENQ, (i == 15) ? 32'hC0DE_0F0F : 32'(i % 5), ~32'(i), 4'd0));
    end
    send(word_of(ACT_ENQ, 32'h1234_5678, 32'h8765_4321, 4'd0));
    send(word_of(ACT_FIND, 32'h0000_0003, 32'h0, 4'd0));
    send(word_of(ACT_FIND, 32'hC0DE_0F0F, 32'h0, 4'd0));
    send(word_of(ACT_REMOVE, 32'h0, 32'h0, 4'd15));
    send(word_of(ACT_REMOVE, 32'h0, 32'h0, 4'd7));
    drain_all();

    for (phase = 0; phase < 9; phase++) begin
      send_steady = (phase == 3) || (phase == 5);
      recv_steady = (phase == 3);
      if (phase == 5) begin
        recv_hold_cycles = 300;
      end
      for (i = 0; i < 100; i++) begin
        send(random_word((phase % 2) == 0 || phase == 5));
      end
      if (phase % 3 == 2) begin
        drain_all();
      end
    end

    drain_all();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
